>>> rtl/vpd_pkg.sv
// Shared constants, types and the saturation pressure table for the VPD block.
`default_nettype none
package vpd_pkg;

  // field widths
  localparam int TEMP_W  = 15;
  localparam int HUM_W   = 14;
  localparam int VPD_W   = 16;
  localparam int TMEAN_W = 14;
  localparam int HMEAN_W = 14;
  localparam int TSUM_W  = 20;
  localparam int HSUM_W  = 20;
  localparam int VSUM_W  = 23;

  // averaging window and the widest value it may take
  localparam int AVG_LEN  = 100;
  localparam int AVG_WMAX = 11;
  localparam int SEED_W   = VPD_W + AVG_WMAX;

  // Tetens table: 5 degC steps, 0..85 degC
  localparam int ES_STEP  = 500;
  localparam int ES_T_TOP = 8500;
  localparam int ES_TOP   = 58068;
  localparam int RH_FULL  = 10000;

  // serial divider: dividend bits, divisor bits, counter bits
  localparam int DIV_NW = 30;
  localparam int DIV_DW = 14;
  localparam int DIV_CW = 5;

  // serial multiplier: multiplicand bits, multiplier bits, counter bits
  localparam int MUL_AW = 16;
  localparam int MUL_BW = 14;
  localparam int MUL_CW = $clog2(MUL_BW + 1);

  typedef logic [DIV_NW-1:0]        div_num_t;
  typedef logic [DIV_DW-1:0]        div_den_t;
  typedef logic [DIV_CW-1:0]        div_cnt_t;
  typedef logic [MUL_AW-1:0]        mul_a_t;
  typedef logic [MUL_BW-1:0]        mul_b_t;
  typedef logic [MUL_AW+MUL_BW-1:0] mul_p_t;

  typedef struct packed {
    logic     start;
    div_cnt_t nbits;   // dividend bits to consume, dividend left-aligned
    div_num_t num;
    div_den_t den;
  } div_req_t;

  typedef struct packed {
    logic   start;
    mul_a_t a;
    mul_b_t b;
  } mul_req_t;

  function automatic logic [15:0] es_tab(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd611;
      5'd1:    v = 16'd872;
      5'd2:    v = 16'd1228;
      5'd3:    v = 16'd1705;
      5'd4:    v = 16'd2338;
      5'd5:    v = 16'd3168;
      5'd6:    v = 16'd4243;
      5'd7:    v = 16'd5623;
      5'd8:    v = 16'd7376;
      5'd9:    v = 16'd9582;
      5'd10:   v = 16'd12337;
      5'd11:   v = 16'd15746;
      5'd12:   v = 16'd19933;
      5'd13:   v = 16'd25038;
      5'd14:   v = 16'd31217;
      5'd15:   v = 16'd38647;
      5'd16:   v = 16'd47525;
      5'd17:   v = 16'd58068;
      default: v = 16'd58068;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> rtl/vpd_sdiv.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module vpd_sdiv (
  input  wire                 clk,
  input  wire                 rst_n,
  input  vpd_pkg::div_req_t   req,
  output logic                busy,
  output vpd_pkg::div_num_t   quot,
  output vpd_pkg::div_den_t   rem
);

  vpd_pkg::div_cnt_t cnt_r;
  vpd_pkg::div_num_t q_r;
  vpd_pkg::div_den_t rem_r;
  vpd_pkg::div_den_t den_r;

  logic [vpd_pkg::DIV_DW:0]   partial;
  logic [vpd_pkg::DIV_DW+1:0] diff;
  logic                       fits;

  assign partial = {rem_r, q_r[vpd_pkg::DIV_NW-1]};
  assign diff    = {1'b0, partial} - {2'b0, den_r};
  assign fits    = ~diff[vpd_pkg::DIV_DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.nbits;
      q_r   <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[vpd_pkg::DIV_DW-1:0] : partial[vpd_pkg::DIV_DW-1:0];
      q_r   <= {q_r[vpd_pkg::DIV_NW-2:0], fits};
      cnt_r <= cnt_r - vpd_pkg::div_cnt_t'(1);
    end
  end

  assign busy = (cnt_r != '0);
  assign quot = q_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

>>> rtl/vpd_smul.sv
// Shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module vpd_smul (
  input  wire                 clk,
  input  wire                 rst_n,
  input  vpd_pkg::mul_req_t   req,
  output logic                busy,
  output vpd_pkg::mul_p_t     prod
);

  logic [vpd_pkg::MUL_CW-1:0] cnt_r;
  vpd_pkg::mul_a_t            a_r;
  vpd_pkg::mul_a_t            hi_r;
  vpd_pkg::mul_b_t            lo_r;
  logic [vpd_pkg::MUL_AW:0]   sum;

  assign sum = {1'b0, hi_r} + {1'b0, (lo_r[0] ? a_r : '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= vpd_pkg::MUL_CW'(vpd_pkg::MUL_BW);
      a_r   <= req.a;
      hi_r  <= '0;
      lo_r  <= req.b;
    end else if (cnt_r != '0) begin
      hi_r  <= sum[vpd_pkg::MUL_AW:1];
      lo_r  <= {sum[0], lo_r[vpd_pkg::MUL_BW-1:1]};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy = (cnt_r != '0);
  assign prod = {hi_r, lo_r};

endmodule
`default_nettype wire

>>> rtl/vpd_with_running_average_top.sv
// Top level: vapor pressure deficit with leaky running averages.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | temperature, humidity
//  out_    | output    | out_valid / out_ready| sample_taken, vpd_now, averages
//
// A sample that is not used goes from the accept straight to the output load.
// A used sample takes longer, less above 85 degC (no table interpolation) and at full
// humidity (no deficit product or division). The shared bit-serial divider (one
// quotient bit per cycle, up to six divisions) and multiplier (up to two products) set it.
// One request is in work at a time.
// Synchronous active-low reset clears all sums, means and the last deficit.
// A result waits in the output register; the block finishes only when it is free.
`default_nettype none
module vpd_with_running_average_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [vpd_pkg::TEMP_W-1:0]       in_temperature,
  input  wire  [vpd_pkg::HUM_W-1:0]        in_humidity,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_sample_taken,
  output logic [vpd_pkg::VPD_W-1:0]        out_vpd_now,
  output logic [vpd_pkg::TMEAN_W-1:0]      out_temp_average,
  output logic [vpd_pkg::HMEAN_W-1:0]      out_hum_average,
  output logic [vpd_pkg::VPD_W-1:0]        out_vpd_average
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DT   = 4'd1;
  localparam logic [3:0] S_MF   = 4'd2;
  localparam logic [3:0] S_DE   = 4'd3;
  localparam logic [3:0] S_VS   = 4'd4;
  localparam logic [3:0] S_MULV = 4'd5;
  localparam logic [3:0] S_DV   = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_MT   = 4'd8;
  localparam logic [3:0] S_MH   = 4'd9;
  localparam logic [3:0] S_MV   = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  localparam int TV_W = vpd_pkg::TEMP_W - 1;  // positive temperature bits

  logic [3:0]                    state_r, state_nxt;
  logic [TV_W-1:0]               t_r;
  logic [vpd_pkg::HUM_W-1:0]     h_r;
  logic [4:0]                    i_r;
  logic [15:0]                   es_r;
  logic                          taken_r;
  logic                          out_valid_r;

  logic [vpd_pkg::TSUM_W-1:0]    temp_sum_r, temp_sum_nxt;
  logic [vpd_pkg::HSUM_W-1:0]    hum_sum_r, hum_sum_nxt;
  logic [vpd_pkg::VSUM_W-1:0]    vpd_sum_r, vpd_sum_nxt;
  logic [vpd_pkg::TMEAN_W-1:0]   temp_mean_r;
  logic [vpd_pkg::HMEAN_W-1:0]   hum_mean_r;
  logic [vpd_pkg::VPD_W-1:0]     vpd_mean_r;
  logic [vpd_pkg::VPD_W-1:0]     last_vpd_r;

  vpd_pkg::div_req_t div_req;
  vpd_pkg::mul_req_t mul_req;
  logic              div_busy, mul_busy;
  vpd_pkg::div_num_t div_quot;
  vpd_pkg::div_den_t div_rem;
  vpd_pkg::mul_p_t   mul_prod;

  logic        in_taken, in_hot, h_full, out_free;
  logic [4:0]  tab_idx;
  logic [15:0] tab_lo, tab_hi;

  vpd_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  vpd_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  // sum - mean floored at zero, plus the new value; caller saturates
  function automatic logic [23:0] leak(input logic [22:0] sum, input logic [15:0] mean,
                                       input logic [15:0] v);
    logic [22:0] s;
    s = (sum >= {7'b0, mean}) ? sum - {7'b0, mean} : '0;
    return {1'b0, s} + {8'b0, v};
  endfunction

  function automatic logic [vpd_pkg::SEED_W-1:0] seed(input logic [15:0] v);
    return vpd_pkg::SEED_W'(v) * vpd_pkg::SEED_W'(vpd_pkg::AVG_LEN);
  endfunction

  assign in_taken = ~in_temperature[vpd_pkg::TEMP_W-1] &&
                    (in_temperature != '0) && (in_humidity != '0);
  assign in_hot   = in_temperature[TV_W-1:0] >= TV_W'(vpd_pkg::ES_T_TOP);
  assign h_full   = h_r >= vpd_pkg::HUM_W'(vpd_pkg::RH_FULL);
  assign out_free = ~out_valid_r | out_ready;

  assign tab_idx = (state_r == S_DT) ? div_quot[4:0] : i_r;
  assign tab_lo  = vpd_pkg::es_tab(tab_idx);
  assign tab_hi  = vpd_pkg::es_tab(tab_idx + 5'd1);

  // running sums: leak when all three are live, then seed any that is zero
  logic [23:0]                 t_lk, h_lk, v_lk;
  logic [vpd_pkg::SEED_W-1:0]  t_sd, h_sd, v_sd;
  logic [vpd_pkg::TSUM_W-1:0]  t_step, t_seed;
  logic [vpd_pkg::HSUM_W-1:0]  h_step, h_seed;
  logic [vpd_pkg::VSUM_W-1:0]  v_step, v_seed;
  logic                        all_live;

  always_comb begin
    all_live = (temp_sum_r != '0) && (hum_sum_r != '0) && (vpd_sum_r != '0);
    t_lk = leak(23'(temp_sum_r), 16'(temp_mean_r), 16'(t_r));
    h_lk = leak(23'(hum_sum_r), 16'(hum_mean_r), 16'(h_r));
    v_lk = leak(vpd_sum_r, vpd_mean_r, last_vpd_r);
    t_sd = seed(16'(t_r));
    h_sd = seed(16'(h_r));
    v_sd = seed(last_vpd_r);

    t_step = temp_sum_r;
    h_step = hum_sum_r;
    v_step = vpd_sum_r;
    if (all_live) begin
      t_step = (|t_lk[23:vpd_pkg::TSUM_W]) ? '1 : t_lk[vpd_pkg::TSUM_W-1:0];
      h_step = (|h_lk[23:vpd_pkg::HSUM_W]) ? '1 : h_lk[vpd_pkg::HSUM_W-1:0];
      v_step = (|v_lk[23:vpd_pkg::VSUM_W]) ? '1 : v_lk[vpd_pkg::VSUM_W-1:0];
    end
    t_seed = (|t_sd[vpd_pkg::SEED_W-1:vpd_pkg::TSUM_W]) ? '1 : t_sd[vpd_pkg::TSUM_W-1:0];
    h_seed = (|h_sd[vpd_pkg::SEED_W-1:vpd_pkg::HSUM_W]) ? '1 : h_sd[vpd_pkg::HSUM_W-1:0];
    v_seed = (|v_sd[vpd_pkg::SEED_W-1:vpd_pkg::VSUM_W]) ? '1 : v_sd[vpd_pkg::VSUM_W-1:0];
    temp_sum_nxt = (t_step == '0) ? t_seed : t_step;
    hum_sum_nxt  = (h_step == '0) ? h_seed : h_step;
    vpd_sum_nxt  = (v_step == '0) ? v_seed : v_step;
  end

  // sequencer and requests to the shared units
  always_comb begin
    state_nxt = state_r;
    div_req   = '0;
    mul_req   = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_taken) begin
            state_nxt = S_OUT;
          end else if (in_hot) begin
            state_nxt = S_VS;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = {in_temperature[TV_W-1:0], (vpd_pkg::DIV_NW-TV_W)'(0)};
            div_req.den   = vpd_pkg::div_den_t'(vpd_pkg::ES_STEP);
            div_req.nbits = vpd_pkg::div_cnt_t'(TV_W);
            state_nxt     = S_DT;
          end
        end
      end
      S_DT: begin
        if (!div_busy) begin
          mul_req.start = 1'b1;
          mul_req.a     = tab_hi - tab_lo;
          mul_req.b     = {5'b0, div_rem[8:0]};
          state_nxt     = S_MF;
        end
      end
      S_MF: begin
        if (!mul_busy) begin
          div_req.start = 1'b1;
          div_req.num   = {mul_prod[22:0] + 23'd250, 7'b0};
          div_req.den   = vpd_pkg::div_den_t'(vpd_pkg::ES_STEP);
          div_req.nbits = vpd_pkg::div_cnt_t'(23);
          state_nxt     = S_DE;
        end
      end
      S_DE: begin
        if (!div_busy) state_nxt = S_VS;
      end
      S_VS: begin
        if (h_full) begin
          state_nxt = S_SUM;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = es_r;
          mul_req.b     = vpd_pkg::mul_b_t'(vpd_pkg::RH_FULL) - h_r;
          state_nxt     = S_MULV;
        end
      end
      S_MULV: begin
        if (!mul_busy) begin
          div_req.start = 1'b1;
          div_req.num   = mul_prod + vpd_pkg::div_num_t'(5000);
          div_req.den   = vpd_pkg::div_den_t'(vpd_pkg::RH_FULL);
          div_req.nbits = vpd_pkg::div_cnt_t'(vpd_pkg::DIV_NW);
          state_nxt     = S_DV;
        end
      end
      S_DV: begin
        if (!div_busy) state_nxt = S_SUM;
      end
      S_SUM: begin
        div_req.start = 1'b1;
        div_req.num   = {temp_sum_nxt, (vpd_pkg::DIV_NW-vpd_pkg::TSUM_W)'(0)};
        div_req.den   = vpd_pkg::div_den_t'(vpd_pkg::AVG_LEN);
        div_req.nbits = vpd_pkg::div_cnt_t'(vpd_pkg::TSUM_W);
        state_nxt     = S_MT;
      end
      S_MT: begin
        if (!div_busy) begin
          div_req.start = 1'b1;
          div_req.num   = {hum_sum_r, (vpd_pkg::DIV_NW-vpd_pkg::HSUM_W)'(0)};
          div_req.den   = vpd_pkg::div_den_t'(vpd_pkg::AVG_LEN);
          div_req.nbits = vpd_pkg::div_cnt_t'(vpd_pkg::HSUM_W);
          state_nxt     = S_MH;
        end
      end
      S_MH: begin
        if (!div_busy) begin
          div_req.start = 1'b1;
          div_req.num   = {vpd_sum_r, (vpd_pkg::DIV_NW-vpd_pkg::VSUM_W)'(0)};
          div_req.den   = vpd_pkg::div_den_t'(vpd_pkg::AVG_LEN);
          div_req.nbits = vpd_pkg::div_cnt_t'(vpd_pkg::VSUM_W);
          state_nxt     = S_MV;
        end
      end
      S_MV: begin
        if (!div_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      temp_sum_r  <= '0;
      hum_sum_r   <= '0;
      vpd_sum_r   <= '0;
      temp_mean_r <= '0;
      hum_mean_r  <= '0;
      vpd_mean_r  <= '0;
      last_vpd_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            t_r     <= in_temperature[TV_W-1:0];
            h_r     <= in_humidity;
            taken_r <= in_taken;
            if (in_hot) es_r <= 16'(vpd_pkg::ES_TOP);
          end
        end
        S_DT: begin
          if (!div_busy) i_r <= div_quot[4:0];
        end
        S_DE: begin
          if (!div_busy) es_r <= tab_lo + div_quot[15:0];
        end
        S_VS: begin
          if (h_full) last_vpd_r <= '0;
        end
        S_DV: begin
          if (!div_busy) last_vpd_r <= div_quot[vpd_pkg::VPD_W-1:0];
        end
        S_SUM: begin
          temp_sum_r <= temp_sum_nxt;
          hum_sum_r  <= hum_sum_nxt;
          vpd_sum_r  <= vpd_sum_nxt;
        end
        S_MT: begin
          if (!div_busy && temp_sum_r != '0) begin
            temp_mean_r <= (|div_quot[vpd_pkg::DIV_NW-1:vpd_pkg::TMEAN_W]) ? '1 :
                           div_quot[vpd_pkg::TMEAN_W-1:0];
          end
        end
        S_MH: begin
          if (!div_busy && hum_sum_r != '0) begin
            hum_mean_r <= (|div_quot[vpd_pkg::DIV_NW-1:vpd_pkg::HMEAN_W]) ? '1 :
                          div_quot[vpd_pkg::HMEAN_W-1:0];
          end
        end
        S_MV: begin
          if (!div_busy && vpd_sum_r != '0) begin
            vpd_mean_r <= (|div_quot[vpd_pkg::DIV_NW-1:vpd_pkg::VPD_W]) ? '1 :
                          div_quot[vpd_pkg::VPD_W-1:0];
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_sample_taken <= taken_r;
            out_vpd_now      <= last_vpd_r;
            out_temp_average <= temp_mean_r;
            out_hum_average  <= hum_mean_r;
            out_vpd_average  <= vpd_mean_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
